FILE: design/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

    // Screen geometry.
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 128;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = $clog2(DEPTH);

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
    localparam logic [ROW_W:0] ROWS_RESET = 7'd25;
    localparam logic [COL_W:0] COLS_RESET = 8'd80;

    // Operation codes.
    localparam logic [1:0] OP_PUT  = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Decoded item class.
    typedef enum logic [3:0] {
        K_FF, K_CR, K_LF, K_BS, K_BEL, K_PUT, K_SET, K_READ, K_NOP
    } kind_t;

    // Datapath action of one microcode step.
    typedef enum logic [3:0] {
        A_NONE, A_LATCH, A_FF, A_CR, A_LF, A_BS, A_BEL, A_SWEEP_INIT,
        A_SWEEP, A_PUT, A_SET, A_RD_ADDR, A_RD_DATA, A_EMIT
    } act_t;

    // Sequencing condition of one microcode step.
    typedef enum logic [2:0] {
        C_STEP, C_GOTO, C_WAIT_IN, C_IF_ROW_VALID, C_IF_MORE, C_HOLD_BUSY,
        C_DISPATCH
    } cond_t;

    // Microcode addresses.
    typedef enum logic [3:0] {
        S_WAIT, S_DISP, S_FF, S_CR, S_LF, S_BS, S_BEL, S_PUT, S_SWEEP,
        S_WRITE, S_SET, S_RD_ADDR, S_RD_DATA, S_DONE
    } step_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
    } uword_t;

    // Status the datapath hands to the sequencer for its jumps.
    typedef struct packed {
        logic  in_valid;
        logic  row_valid;
        logic  sweep_last;
        logic  out_busy;
        kind_t kind;
    } seq_stat_t;

    // The control program.
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        unique case (s)
            S_WAIT:    w = '{act: A_LATCH,      cond: C_WAIT_IN,      target: S_DISP};
            S_DISP:    w = '{act: A_NONE,       cond: C_DISPATCH,     target: S_DONE};
            S_FF:      w = '{act: A_FF,         cond: C_GOTO,         target: S_DONE};
            S_CR:      w = '{act: A_CR,         cond: C_GOTO,         target: S_DONE};
            S_LF:      w = '{act: A_LF,         cond: C_GOTO,         target: S_DONE};
            S_BS:      w = '{act: A_BS,         cond: C_GOTO,         target: S_DONE};
            S_BEL:     w = '{act: A_BEL,        cond: C_GOTO,         target: S_DONE};
            S_PUT:     w = '{act: A_SWEEP_INIT, cond: C_IF_ROW_VALID, target: S_WRITE};
            S_SWEEP:   w = '{act: A_SWEEP,      cond: C_IF_MORE,      target: S_SWEEP};
            S_WRITE:   w = '{act: A_PUT,        cond: C_GOTO,         target: S_DONE};
            S_SET:     w = '{act: A_SET,        cond: C_GOTO,         target: S_DONE};
            S_RD_ADDR: w = '{act: A_RD_ADDR,    cond: C_STEP,         target: S_RD_DATA};
            S_RD_DATA: w = '{act: A_RD_DATA,    cond: C_STEP,         target: S_DONE};
            S_DONE:    w = '{act: A_EMIT,       cond: C_HOLD_BUSY,    target: S_WAIT};
            default:   w = '{act: A_NONE,       cond: C_GOTO,         target: S_WAIT};
        endcase
        return w;
    endfunction

    // Entry step of each item class.
    function automatic step_t entry_step(input kind_t k);
        step_t s;
        unique case (k)
            K_FF:    s = S_FF;
            K_CR:    s = S_CR;
            K_LF:    s = S_LF;
            K_BS:    s = S_BS;
            K_BEL:   s = S_BEL;
            K_PUT:   s = S_PUT;
            K_SET:   s = S_SET;
            K_READ:  s = S_RD_ADDR;
            default: s = S_DONE;
        endcase
        return s;
    endfunction

    // Classify an incoming word.
    function automatic kind_t decode_kind(input logic [1:0] op, input logic [7:0] ch);
        kind_t k;
        if (op == OP_PUT) begin
            if (ch == CH_FF)       k = K_FF;
            else if (ch == CH_CR)  k = K_CR;
            else if (ch == CH_LF)  k = K_LF;
            else if (ch == CH_BS)  k = K_BS;
            else if (ch == CH_BEL) k = K_BEL;
            else                   k = K_PUT;
        end
        else if (op == OP_SET) begin
            k = K_SET;
        end
        else if (op == OP_READ) begin
            k = K_READ;
        end
        else begin
            k = K_NOP;
        end
        return k;
    endfunction

    // Physical row of a logical row on the ring.
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] base,
                                                  input logic [ROW_W-1:0] ofs);
        logic [ROW_W:0] sum;
        sum = {1'b0, base} + {1'b0, ofs};
        if (sum >= (ROW_W+1)'(MAX_ROWS)) begin
            sum = sum - (ROW_W+1)'(MAX_ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    // Store address of a physical row and a column.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(prow) * ADDR_W'(MAX_COLS) + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

FILE: design/tcw_seq.sv
`default_nettype none

module tcw_seq
    import tcw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire seq_stat_t stat,
    output step_t          step,
    output uword_t         uword
);

    step_t step_reg;
    step_t step_next;
    step_t step_inc;

    // Fetch the control word of the current step.
    always_comb
    begin
        uword = ucode(step_reg);
        step  = step_reg;
    end

    // Choose the next step from the condition field.
    always_comb
    begin
        step_inc = step_t'(step_reg + 4'd1);
        unique case (uword.cond)
            C_STEP:         step_next = step_inc;
            C_GOTO:         step_next = uword.target;
            C_WAIT_IN:      step_next = stat.in_valid ? step_inc : step_reg;
            C_IF_ROW_VALID: step_next = stat.row_valid ? uword.target : step_inc;
            C_IF_MORE:      step_next = stat.sweep_last ? step_inc : uword.target;
            C_HOLD_BUSY:    step_next = stat.out_busy ? step_reg : uword.target;
            C_DISPATCH:     step_next = entry_step(stat.kind);
            default:        step_next = S_WAIT;
        endcase
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg <= S_WAIT;
        end
        else begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/tcw_store.sv
`default_nettype none

module tcw_store
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]             rd_data
);

    logic [7:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/text_console_writer_unit.sv
// Each word runs through the microcode steps in order: wait, dispatch, the steps
// of its class and the emit step. A read has an address and a data step, and a
// printed character a sweep setup and a write step; the first character written
// into a blanked row is preceded by a sweep that fills the row with spaces over
// the write port. A new word is taken only once the last result is emitted.
// Reset: cursor and ring offset go to 0, all rows are marked blank and read
// as spaces; no clearing pass is needed, the block takes words at once.
`default_nettype none

module text_console_writer_unit
    import tcw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           op,
    input  wire logic [7:0]           char_code,
    input  wire logic [ROW_W-1:0]     target_row,
    input  wire logic [COL_W-1:0]     target_col,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      beep,
    output logic [ROW_W-1:0]          cursor_row_out,
    output logic [COL_W-1:0]          cursor_col_out,
    output logic [7:0]                cell_char,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data
);

    seq_stat_t stat;
    step_t     step;
    uword_t    uw;

    logic [ROW_W:0]      rows_cfg_reg;
    logic [COL_W:0]      cols_cfg_reg;
    logic [ROW_W:0]      rows_eff;
    logic [COL_W:0]      cols_eff;
    logic [ROW_W-1:0]    cursor_row_reg;
    logic [COL_W-1:0]    cursor_col_reg;
    logic [ROW_W-1:0]    offset_reg;
    logic [MAX_ROWS-1:0] row_valid_reg;
    logic [COL_W-1:0]    sweep_cnt_reg;
    kind_t               kind_reg;
    logic [7:0]          ch_reg;
    logic [ROW_W-1:0]    trow_reg;
    logic [COL_W-1:0]    tcol_reg;
    logic                beep_reg;
    logic [7:0]          cell_reg;
    logic                rd_ok_reg;
    logic                rd_live_reg;
    logic                out_valid_reg;

    logic                in_acc;
    logic                out_busy;
    logic [ROW_W-1:0]    cur_phys;
    logic [ROW_W-1:0]    tgt_phys;
    logic                tgt_inrange;
    logic [ROW_W:0]      rows_m1;
    logic [ROW_W:0]      row_inc;
    logic                lf_scroll;
    logic [ROW_W-1:0]    lf_row;
    logic [ROW_W-1:0]    off_inc;
    logic [ROW_W-1:0]    lf_clear_row;
    logic [COL_W:0]      col_inc;
    logic                col_wrap;
    logic [ROW_W-1:0]    row_clamped;
    logic [COL_W-1:0]    col_clamped;
    logic                sweep_last;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [7:0]          rd_data;

    // Sequencer and character store.
    tcw_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .step  (step),
        .uword (uw)
    );

    tcw_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Handshakes.
    assign in_stall  = (uw.act != A_LATCH);
    assign in_acc    = in_valid && !in_stall;
    assign out_busy  = out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rows_cfg_reg <= ROWS_RESET;
            cols_cfg_reg <= COLS_RESET;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ROWS: rows_cfg_reg <= cfg_data[ROW_W:0];
                CFG_COLS: cols_cfg_reg <= cfg_data[COL_W:0];
                default:  ;
            endcase
        end
    end

    // Screen size in use, clamped to the store.
    always_comb
    begin
        if (rows_cfg_reg == '0)
            rows_eff = (ROW_W+1)'(1);
        else if (rows_cfg_reg > (ROW_W+1)'(MAX_ROWS))
            rows_eff = (ROW_W+1)'(MAX_ROWS);
        else
            rows_eff = rows_cfg_reg;
        if (cols_cfg_reg == '0)
            cols_eff = (COL_W+1)'(1);
        else if (cols_cfg_reg > (COL_W+1)'(MAX_COLS))
            cols_eff = (COL_W+1)'(MAX_COLS);
        else
            cols_eff = cols_cfg_reg;
    end

    // Cursor arithmetic shared by line feed, wrap and clamping.
    always_comb
    begin
        rows_m1      = rows_eff - (ROW_W+1)'(1);
        cur_phys     = phys_row(offset_reg, cursor_row_reg);
        tgt_phys     = phys_row(offset_reg, trow_reg);
        tgt_inrange  = ({1'b0, trow_reg} < rows_eff) && ({1'b0, tcol_reg} < cols_eff);
        row_inc      = {1'b0, cursor_row_reg} + (ROW_W+1)'(1);
        lf_scroll    = (row_inc >= rows_eff);
        lf_row       = lf_scroll ? rows_m1[ROW_W-1:0] : row_inc[ROW_W-1:0];
        off_inc      = phys_row(offset_reg, ROW_W'(1));
        lf_clear_row = phys_row(off_inc, rows_m1[ROW_W-1:0]);
        col_inc      = {1'b0, cursor_col_reg} + (COL_W+1)'(1);
        col_wrap     = (col_inc >= cols_eff);
        row_clamped  = ({1'b0, cursor_row_reg} >= rows_eff) ? rows_m1[ROW_W-1:0]
                                                           : cursor_row_reg;
        col_clamped  = ({1'b0, cursor_col_reg} >= cols_eff)
                       ? COL_W'(cols_eff - (COL_W+1)'(1)) : cursor_col_reg;
        sweep_last   = (sweep_cnt_reg == COL_W'(MAX_COLS - 1));
    end

    // Status for the sequencer's jumps.
    assign stat = '{in_valid:   in_valid,
                    row_valid:  row_valid_reg[cur_phys],
                    sweep_last: sweep_last,
                    out_busy:   out_busy,
                    kind:       kind_reg};

    // Cursor and ring offset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            offset_reg     <= '0;
        end
        else begin
            unique case (uw.act)
                A_LATCH:
                begin
                    if (in_acc) begin
                        cursor_row_reg <= row_clamped;
                        cursor_col_reg <= col_clamped;
                    end
                end
                A_FF:
                begin
                    cursor_row_reg <= '0;
                    cursor_col_reg <= '0;
                    offset_reg     <= '0;
                end
                A_CR:
                begin
                    cursor_col_reg <= '0;
                end
                A_LF:
                begin
                    cursor_row_reg <= lf_row;
                    if (lf_scroll) offset_reg <= off_inc;
                end
                A_BS:
                begin
                    if (cursor_col_reg != '0) cursor_col_reg <= cursor_col_reg - COL_W'(1);
                end
                A_PUT:
                begin
                    if (col_wrap) begin
                        cursor_col_reg <= '0;
                        cursor_row_reg <= lf_row;
                        if (lf_scroll) offset_reg <= off_inc;
                    end
                    else begin
                        cursor_col_reg <= col_inc[COL_W-1:0];
                    end
                end
                A_SET:
                begin
                    if (tgt_inrange) begin
                        cursor_row_reg <= trow_reg;
                        cursor_col_reg <= tcol_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // Row valid bits: a row that is not valid reads as all spaces.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            row_valid_reg <= '0;
        end
        else begin
            unique case (uw.act)
                A_FF:    row_valid_reg <= '0;
                A_LF:    if (lf_scroll) row_valid_reg[lf_clear_row] <= 1'b0;
                A_PUT:   if (col_wrap && lf_scroll) row_valid_reg[lf_clear_row] <= 1'b0;
                A_SWEEP: if (sweep_last) row_valid_reg[cur_phys] <= 1'b1;
                default: ;
            endcase
        end
    end

    // Latched word, sweep counter and per-word results.
    always_ff @(posedge clk)
    begin
        unique case (uw.act)
            A_LATCH:
            begin
                if (in_acc) begin
                    kind_reg <= decode_kind(op, char_code);
                    ch_reg   <= (char_code == CH_TAB) ? CH_SPACE : char_code;
                    trow_reg <= target_row;
                    tcol_reg <= target_col;
                    beep_reg <= 1'b0;
                    cell_reg <= '0;
                end
            end
            A_BS:         if (cursor_col_reg == '0) beep_reg <= 1'b1;
            A_BEL:        beep_reg <= 1'b1;
            A_SWEEP_INIT: sweep_cnt_reg <= '0;
            A_SWEEP:      sweep_cnt_reg <= sweep_cnt_reg + COL_W'(1);
            A_RD_ADDR:
            begin
                rd_ok_reg   <= tgt_inrange;
                rd_live_reg <= row_valid_reg[tgt_phys];
            end
            A_RD_DATA:
            begin
                cell_reg <= rd_ok_reg ? (rd_live_reg ? rd_data : CH_SPACE) : 8'h00;
            end
            default: ;
        endcase
    end

    // Store access for each action.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cell_addr(cur_phys, cursor_col_reg);
        wr_data = CH_SPACE;
        rd_en   = (uw.act == A_RD_ADDR);
        rd_addr = cell_addr(tgt_phys, tcol_reg);
        unique case (uw.act)
            A_SWEEP:
            begin
                wr_en   = 1'b1;
                wr_addr = cell_addr(cur_phys, sweep_cnt_reg);
            end
            A_BS:
            begin
                wr_en   = (cursor_col_reg != '0) && row_valid_reg[cur_phys];
                wr_addr = cell_addr(cur_phys, cursor_col_reg - COL_W'(1));
            end
            A_PUT:
            begin
                wr_en   = 1'b1;
                wr_data = ch_reg;
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (uw.act == A_EMIT && !out_busy) begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (uw.act == A_EMIT && !out_busy) begin
            beep           <= beep_reg;
            cursor_row_out <= cursor_row_reg;
            cursor_col_out <= cursor_col_reg;
            cell_char      <= cell_reg;
        end
    end

    // An accepted word is always followed by the dispatch step.
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> step == S_DISP)
        else $error("accepted word not followed by dispatch");

    // A new result only appears after the emit step.
    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step == S_DONE))
        else $error("result raised outside the emit step");

    // A character is only written into a row that has been filled.
    a_put_row_filled: assert property (@(posedge clk) disable iff (!rst_n)
        step == S_WRITE |-> row_valid_reg[cur_phys])
        else $error("character written into a blank row");

endmodule

`default_nettype wire

FILE: verif/text_console_writer_unit_tb.sv
`default_nettype none

module text_console_writer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    // Codes that the package leaves unnamed.
    localparam logic [1:0]           OP_NONE     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int PHASE_WORDS  = 138;
    localparam int NUM_SETTINGS = 11;
    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE_CYCLES = 200;

    typedef struct packed {
        logic [1:0]       op;
        logic [7:0]       ch;
        logic [ROW_W-1:0] trow;
        logic [COL_W-1:0] tcol;
    } console_word_t;

    typedef struct packed {
        logic             beep;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [7:0]       rd_char;
    } console_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [1:0]           op = '0;
    logic [7:0]           char_code = '0;
    logic [ROW_W-1:0]     target_row = '0;
    logic [COL_W-1:0]     target_col = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 beep;
    logic [ROW_W-1:0]     cursor_row_out;
    logic [COL_W-1:0]     cursor_col_out;
    logic [7:0]           cell_char;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data = '0;

    text_console_writer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .char_code      (char_code),
        .target_row     (target_row),
        .target_col     (target_col),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .beep           (beep),
        .cursor_row_out (cursor_row_out),
        .cursor_col_out (cursor_col_out),
        .cell_char      (cell_char),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    console_word_t   pending_words[$];
    console_result_t expected_results[$];
    int              words_queued = 0;
    int              fail_count = 0;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              idle_cycles = 0;

    // Mirror of the screen: store, cursor, ring offset and registers.
    logic [7:0]       screen_mirror [DEPTH];
    logic [ROW_W-1:0] mirror_row;
    logic [COL_W-1:0] mirror_col;
    logic [ROW_W-1:0] mirror_top;
    logic [ROW_W:0]   rows_reg;
    logic [COL_W:0]   cols_reg;

    function automatic void blank_screen();
        foreach (screen_mirror[i])
            screen_mirror[i] = CH_SPACE;
    endfunction

    function automatic int shown_rows();
        if (rows_reg == 0)
            return 1;
        else if (rows_reg > MAX_ROWS)
            return MAX_ROWS;
        return int'(rows_reg);
    endfunction

    function automatic int shown_cols();
        if (cols_reg == 0)
            return 1;
        else if (cols_reg > MAX_COLS)
            return MAX_COLS;
        return int'(cols_reg);
    endfunction

    function automatic int mirror_addr(int row, int col);
        return ((int'(mirror_top) + row) % MAX_ROWS) * MAX_COLS + col;
    endfunction

    // Move down one row; at the bottom the ring advances and the new
    // bottom row is blanked.
    function automatic void advance_line(int rows);
        int r;
        int prow;
        int c;
        r = int'(mirror_row) + 1;
        if (r >= rows)
        begin
            mirror_top = ROW_W'((int'(mirror_top) + 1) % MAX_ROWS);
            prow = (int'(mirror_top) + rows - 1) % MAX_ROWS;
            for (c = 0; c < MAX_COLS; c++)
                screen_mirror[prow * MAX_COLS + c] = CH_SPACE;
            r = rows - 1;
        end
        mirror_row = ROW_W'(r);
    endfunction

    // Apply one word to the mirror and return the result it should give.
    function automatic console_result_t console_step(console_word_t w);
        console_result_t res;
        int rows;
        int cols;
        int next_col;
        rows = shown_rows();
        cols = shown_cols();
        res = '0;

        // A shrunken screen pulls the cursor back inside first.
        if (int'(mirror_row) >= rows)
            mirror_row = ROW_W'(rows - 1);
        if (int'(mirror_col) >= cols)
            mirror_col = COL_W'(cols - 1);

        case (w.op)
            OP_PUT:
            begin
                if (w.ch == CH_FF)
                begin
                    blank_screen();
                    mirror_top = '0;
                    mirror_row = '0;
                    mirror_col = '0;
                end
                else if (w.ch == CH_CR)
                    mirror_col = '0;
                else if (w.ch == CH_LF)
                    advance_line(rows);
                else if (w.ch == CH_BS)
                begin
                    if (mirror_col != 0)
                    begin
                        mirror_col = mirror_col - 1'b1;
                        screen_mirror[mirror_addr(mirror_row, mirror_col)] = CH_SPACE;
                    end
                    else
                        res.beep = 1'b1;
                end
                else if (w.ch == CH_BEL)
                    res.beep = 1'b1;
                else
                begin
                    screen_mirror[mirror_addr(mirror_row, mirror_col)] =
                        (w.ch == CH_TAB) ? CH_SPACE : w.ch;
                    next_col = int'(mirror_col) + 1;
                    if (next_col >= cols)
                    begin
                        mirror_col = '0;
                        advance_line(rows);
                    end
                    else
                        mirror_col = COL_W'(next_col);
                end
            end
            OP_SET:
            begin
                if (int'(w.trow) < rows && int'(w.tcol) < cols)
                begin
                    mirror_row = w.trow;
                    mirror_col = w.tcol;
                end
            end
            OP_READ:
            begin
                if (int'(w.trow) < rows && int'(w.tcol) < cols)
                    res.rd_char = screen_mirror[mirror_addr(w.trow, w.tcol)];
            end
            default:
            begin
            end
        endcase

        res.row = mirror_row;
        res.col = mirror_col;
        return res;
    endfunction

    task automatic push_word(input logic [1:0] w_op, input logic [7:0] w_ch,
                             input int w_row, input int w_col);
        console_word_t w;
        w.op = w_op;
        w.ch = w_ch;
        w.trow = ROW_W'(w_row);
        w.tcol = COL_W'(w_col);
        pending_words.push_back(w);
        words_queued++;
    endtask

    function automatic logic [7:0] text_char();
        if ($urandom_range(0, 99) < 15)
            return 8'($urandom);
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    // A set-cursor, a short run of characters, reads of the written cells
    // and sometimes a new line.
    task automatic queue_text_burst(input int rows, input int cols);
        int r;
        int c;
        int n;
        int j;
        r = $urandom_range(0, rows - 1);
        c = $urandom_range(0, cols - 1);
        n = $urandom_range(1, 8);
        push_word(OP_SET, 8'($urandom), r, c);
        for (j = 0; j < n; j++)
            push_word(OP_PUT, text_char(), $urandom, $urandom);
        for (j = 0; j < n; j++)
        begin
            if (c + j < cols)
                push_word(OP_READ, 8'($urandom), r, c + j);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            push_word(OP_PUT, CH_CR, $urandom, $urandom);
            push_word(OP_PUT, CH_LF, $urandom, $urandom);
        end
    endtask

    // One stray word: control codes, any byte, out-of-range targets, unused op.
    task automatic queue_noise_word(input int rows, input int cols);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            push_word(OP_PUT, CH_CR, $urandom, $urandom);
        else if (pick < 20)
            push_word(OP_PUT, CH_LF, $urandom, $urandom);
        else if (pick < 28)
            push_word(OP_PUT, CH_BS, $urandom, $urandom);
        else if (pick < 32)
            push_word(OP_PUT, CH_BEL, $urandom, $urandom);
        else if (pick < 36)
            push_word(OP_PUT, CH_TAB, $urandom, $urandom);
        else if (pick < 38)
            push_word(OP_PUT, CH_FF, $urandom, $urandom);
        else if (pick < 55)
            push_word(OP_PUT, 8'($urandom), $urandom, $urandom);
        else if (pick < 65)
            push_word(OP_SET, 8'($urandom), $urandom, $urandom);
        else if (pick < 75)
            push_word(OP_SET, 8'($urandom), $urandom_range(0, rows - 1),
                      $urandom_range(0, cols - 1));
        else if (pick < 85)
            push_word(OP_READ, 8'($urandom), $urandom_range(0, rows - 1),
                      $urandom_range(0, cols - 1));
        else if (pick < 93)
            push_word(OP_READ, 8'($urandom), $urandom, $urandom);
        else
            push_word(OP_NONE, 8'($urandom), $urandom, $urandom);
    endtask

    task automatic queue_random_words(input int count);
        int start;
        start = words_queued;
        while (words_queued - start < count)
        begin
            if ($urandom_range(0, 99) < 60)
                queue_text_burst(shown_rows(), shown_cols());
            else
                queue_noise_word(shown_rows(), shown_cols());
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_ROWS)
            rows_reg = data[ROW_W:0];
        else if (idx == CFG_COLS)
            cols_reg = data;
    endtask

    // Word driver: predicts each accepted word, then offers the next one.
    always @(posedge clk)
    begin : word_driver
        console_word_t next_word;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(console_step('{op: op, ch: char_code,
                                                          trow: target_row,
                                                          tcol: target_col}));
            if (!in_valid || !in_stall)
            begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    op <= next_word.op;
                    char_code <= next_word.ch;
                    target_row <= next_word.trow;
                    target_col <= next_word.tcol;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compares each delivered result against the oldest prediction.
    always @(posedge clk)
    begin : result_monitor
        console_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: beep=%0d row=%0d col=%0d cell=%02h",
                             beep, cursor_row_out, cursor_col_out, cell_char);
            end
            else
            begin
                want = expected_results.pop_front();
                if (want.beep !== beep || want.row !== cursor_row_out ||
                    want.col !== cursor_col_out || want.rd_char !== cell_char)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected beep=%0d row=%0d col=%0d cell=%02h, %s",
                                 want.beep, want.row, want.col, want.rd_char,
                                 $sformatf("got beep=%0d row=%0d col=%0d cell=%02h",
                                           beep, cursor_row_out, cursor_col_out,
                                           cell_char));
                end
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Watchdog on cycles with no handshake on any channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial
    begin : stimulus
        logic [7:0] rows_setting [NUM_SETTINGS];
        logic [7:0] cols_setting [NUM_SETTINGS];
        int phase;

        // Register settings, extremes and clamped values included.
        rows_setting = '{8'd1, 8'd64, 8'd0,  8'hFF, 8'd3, 8'd64, 8'd1,   8'h80, 8'd12,
                         8'd33, 8'd2};
        cols_setting = '{8'd1, 8'd128, 8'd0, 8'hFF, 8'd5, 8'd1,  8'd128, 8'd7,  8'd40,
                         8'd100, 8'd2};

        blank_screen();
        mirror_row = '0;
        mirror_col = '0;
        mirror_top = '0;
        rows_reg = ROWS_RESET;
        cols_reg = COLS_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words on the reset screen of 25 by 80.
        push_word(OP_READ, 8'h00, 0, 0);
        push_word(OP_PUT, 8'h41, 0, 0);
        push_word(OP_PUT, CH_TAB, 0, 0);
        push_word(OP_PUT, 8'h42, 0, 0);
        push_word(OP_READ, 8'h00, 0, 0);
        push_word(OP_READ, 8'h00, 0, 1);
        push_word(OP_PUT, CH_BEL, 0, 0);
        push_word(OP_PUT, CH_BS, 0, 0);
        push_word(OP_READ, 8'h00, 0, 2);
        push_word(OP_PUT, CH_CR, 0, 0);
        push_word(OP_PUT, CH_BS, 0, 0);
        push_word(OP_PUT, 8'h00, 63, 127);
        push_word(OP_SET, 8'h00, 24, 79);
        push_word(OP_PUT, 8'hFF, 0, 0);
        push_word(OP_PUT, CH_LF, 0, 0);
        push_word(OP_READ, 8'h00, 22, 79);
        push_word(OP_SET, 8'h00, 25, 0);
        push_word(OP_SET, 8'h00, 0, 80);
        push_word(OP_SET, 8'h00, 63, 127);
        push_word(OP_READ, 8'hFF, 63, 127);
        push_word(OP_NONE, 8'hFF, 63, 127);
        push_word(OP_PUT, CH_FF, 0, 0);
        push_word(OP_READ, 8'h00, 22, 79);
        push_word(OP_READ, 8'h00, 24, 79);
        queue_random_words(PHASE_WORDS);

        // Each later phase: new screen size, then random words under one
        // of four idling patterns.
        for (phase = 0; phase < NUM_SETTINGS; phase++)
        begin
            wait_drained();
            write_register(CFG_ROWS, rows_setting[phase]);
            write_register(CFG_COLS, cols_setting[phase]);
            write_register(($urandom_range(0, 1) == 1) ? CFG_SPARE_A : CFG_SPARE_B,
                           8'($urandom));
            case ((phase + 1) % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 75;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 75;
                end
                default:
                begin
                    send_idle_pct = 36;
                    recv_stall_pct = 36;
                end
            endcase
            queue_random_words(PHASE_WORDS);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
